/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers. They assume a clock named clk and an
// active-low reset named rst_n in the module that uses them.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Condition holds at every clock edge outside reset
`define ASSERT_INV(label, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("invariant violated");

// Antecedent implies consequent in the same cycle
`define ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication violated");

`else

`define ASSERT_INV(label, expr)
`define ASSERT_IMPL(label, ante, cons)

`endif

`endif

/* rtl/hsl2rgb_pkg.sv */
// ----------------------------------------------------------------------------
// HSL to RGB package
// Sextant codes and fixed constants of the HSL to RGB converter.
// ----------------------------------------------------------------------------
package hsl2rgb_pkg;

    // Hue is scaled by six to pick one of six sextants
    localparam int unsigned HUE_SECTORS = 6;
    localparam int unsigned SEXT_W      = 3;

    // Sextant of the color wheel, named by the channel order it produces
    typedef enum logic [SEXT_W-1:0] {
        SEXT_RED_GREEN_UP   = 3'd0,  // r=v,    g=mid1, b=m
        SEXT_RED_DOWN       = 3'd1,  // r=mid2, g=v,    b=m
        SEXT_BLUE_UP        = 3'd2,  // r=m,    g=v,    b=mid1
        SEXT_GREEN_DOWN     = 3'd3,  // r=m,    g=mid2, b=v
        SEXT_RED_UP         = 3'd4,  // r=mid1, g=m,    b=v
        SEXT_BLUE_DOWN      = 3'd5   // r=v,    g=m,    b=mid2
    } sextant_t;

endpackage

/* rtl/hsl_to_rgb_converter.sv */
// ----------------------------------------------------------------------------
// HSL to RGB converter
// Fixed-point conversion of one HSL pixel to RGB in a five-stage pipeline.
// ----------------------------------------------------------------------------
// Usage:
//   Input items arrive on s_axis_* (hue, saturation, lightness) and results
//   leave on m_axis_* (red, green, blue). An item moves on a clock edge where
//   tvalid and tready are both high.
//   Pipeline: stage 1 forms l*s and hue*6, stage 2 divides l*s by full scale,
//   stage 3 forms the top value v and bottom value m, stage 4 multiplies the
//   span by the hue fraction, stage 5 picks the channel order and registers
//   the result.
//   Stages: an accepted item passes the stage 1 to stage 5 registers in
//   order (five register stages) before its result is valid on m_axis.
//   Throughput: one item per clock while m_axis_tready is high.
//   Each stage holds its item while the next one is full and stalled, so a
//   stalled receiver only blocks s_axis_tready once every stage is occupied;
//   bubbles are squeezed out and nothing is lost or repeated.
//   Reset clears all stage valid bits; the pipeline comes up empty and ready.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module hsl_to_rgb_converter #(
    parameter int CHANNEL_BITS = 8,
    parameter int HUE_BITS     = 16,
    localparam int IN_W        = HUE_BITS + 2 * CHANNEL_BITS,
    localparam int IN_TDATA_W  = ((IN_W + 7) / 8) * 8,
    localparam int OUT_W       = 3 * CHANNEL_BITS,
    localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8
) (
    input  logic                   clk,
    input  logic                   rst_n,

    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // hue, saturation, lightness

    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata    // red, green, blue
);

    import hsl2rgb_pkg::*;

    localparam int C       = CHANNEL_BITS;
    localparam int H       = HUE_BITS;
    localparam int HUE6_W  = H + SEXT_W;
    localparam int NSTAGE  = 5;
    localparam logic [C-1:0] MAXC = {C{1'b1}};

    // Stage valid bits and per-stage load enables
    logic [NSTAGE:1] vld_reg;
    logic [NSTAGE:1] en;

    // Stage 1
    logic [HUE6_W-1:0] hue6_s1_reg, hue6_s1_next;
    logic [2*C-1:0]    ls_s1_reg,   ls_s1_next;
    logic [C-1:0]      sat_s1_reg,  light_s1_reg;
    // Stage 2
    logic [C-1:0]      prod_s2_reg, prod_s2_next;
    logic [C-1:0]      sat_s2_reg,  light_s2_reg;
    sextant_t          sext_s2_reg;
    logic [H-1:0]      fract_s2_reg;
    // Stage 3
    logic [C-1:0]      v_s3_reg, v_s3_next;
    logic [C-1:0]      m_s3_reg, m_s3_next;
    logic [C-1:0]      light_s3_reg;
    sextant_t          sext_s3_reg;
    logic [H-1:0]      fract_s3_reg;
    // Stage 4
    logic [C-1:0]      v_s4_reg, m_s4_reg;
    logic [C-1:0]      ramp_s4_reg, ramp_s4_next;
    logic [C-1:0]      light_s4_reg;
    sextant_t          sext_s4_reg;
    // Stage 5 (output)
    logic [C-1:0]      red_reg,   red_next;
    logic [C-1:0]      green_reg, green_next;
    logic [C-1:0]      blue_reg,  blue_next;

    // Input field unpacking
    logic [H-1:0] in_hue;
    logic [C-1:0] in_sat;
    logic [C-1:0] in_light;

    assign in_hue   = s_axis_tdata[H-1:0];
    assign in_sat   = s_axis_tdata[H +: C];
    assign in_light = s_axis_tdata[H + C +: C];

    // Backpressure: a stage loads when empty or when its successor moves on
    always_comb
    begin
        en[NSTAGE] = !vld_reg[NSTAGE] || m_axis_tready;
        for (int k = NSTAGE - 1; k >= 1; k--)
        begin
            en[k] = !vld_reg[k] || en[k + 1];
        end
    end

    assign s_axis_tready = en[1];

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (en[1])
            begin
                vld_reg[1] <= s_axis_tvalid;
            end
            for (int k = 2; k <= NSTAGE; k++)
            begin
                if (en[k])
                begin
                    vld_reg[k] <= vld_reg[k - 1];
                end
            end
        end
    end

    // Stage 1: l*s product and hue scaled by six
    always_comb
    begin
        ls_s1_next   = (2 * C)'(in_light) * (2 * C)'(in_sat);
        hue6_s1_next = HUE6_W'(in_hue) * HUE6_W'(HUE_SECTORS);
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            ls_s1_reg    <= ls_s1_next;
            hue6_s1_reg  <= hue6_s1_next;
            sat_s1_reg   <= in_sat;
            light_s1_reg <= in_light;
        end
    end

    // Stage 2: exact floor(x / (2^C - 1)) for x <= (2^C - 1)^2
    logic [2*C:0] div_sum;

    always_comb
    begin
        div_sum      = (2 * C + 1)'(ls_s1_reg) + (2 * C + 1)'(ls_s1_reg >> C)
                     + (2 * C + 1)'(1);
        prod_s2_next = div_sum[2 * C - 1:C];
    end

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            prod_s2_reg  <= prod_s2_next;
            sat_s2_reg   <= sat_s1_reg;
            light_s2_reg <= light_s1_reg;
            sext_s2_reg  <= sextant_t'(hue6_s1_reg[HUE6_W-1:H]);
            fract_s2_reg <= hue6_s1_reg[H-1:0];
        end
    end

    // Stage 3: top value v (clamped) and bottom value m = 2l - v (clamped at 0)
    logic         low_half;
    logic [C:0]   v_raw;
    logic [C+1:0] m_diff;

    always_comb
    begin
        low_half = {light_s2_reg, 1'b0} <= (C + 1)'(MAXC);
        if (low_half)
        begin
            v_raw = (C + 1)'(light_s2_reg) + (C + 1)'(prod_s2_reg);
        end
        else
        begin
            v_raw = (C + 1)'(light_s2_reg) + (C + 1)'(sat_s2_reg)
                  - (C + 1)'(prod_s2_reg);
        end
        v_s3_next = (v_raw > (C + 1)'(MAXC)) ? MAXC : v_raw[C-1:0];
        m_diff    = {1'b0, light_s2_reg, 1'b0} - (C + 2)'(v_s3_next);
        // v never falls below l, so a non-negative m fits in C bits
        m_s3_next = m_diff[C + 1] ? '0 : m_diff[C-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            v_s3_reg     <= v_s3_next;
            m_s3_reg     <= m_s3_next;
            light_s3_reg <= light_s2_reg;
            sext_s3_reg  <= sext_s2_reg;
            fract_s3_reg <= fract_s2_reg;
        end
    end

    // Stage 4: ramp = (v - m) * fract >> H
    logic [C-1:0]   span;
    logic [C+H-1:0] ramp_prod;

    always_comb
    begin
        span         = (v_s3_reg >= m_s3_reg) ? (v_s3_reg - m_s3_reg) : '0;
        ramp_prod    = (C + H)'(span) * (C + H)'(fract_s3_reg);
        ramp_s4_next = ramp_prod[C + H - 1:H];
    end

    always_ff @(posedge clk)
    begin
        if (en[4])
        begin
            v_s4_reg     <= v_s3_reg;
            m_s4_reg     <= m_s3_reg;
            ramp_s4_reg  <= ramp_s4_next;
            light_s4_reg <= light_s3_reg;
            sext_s4_reg  <= sext_s3_reg;
        end
    end

    // Stage 5: rising/falling mids and channel order by sextant
    logic [C:0]   mid1_sum;
    logic [C-1:0] mid1;
    logic [C-1:0] mid2;

    always_comb
    begin
        mid1_sum = (C + 1)'(m_s4_reg) + (C + 1)'(ramp_s4_reg);
        mid1     = mid1_sum[C] ? MAXC : mid1_sum[C-1:0];
        // ramp never exceeds v - m, so this cannot underflow
        mid2     = v_s4_reg - ramp_s4_reg;

        red_next   = light_s4_reg;
        green_next = light_s4_reg;
        blue_next  = light_s4_reg;

        // Zero top value leaves gray at lightness
        if (v_s4_reg != '0)
        begin
            unique case (sext_s4_reg)
                SEXT_RED_GREEN_UP:
                begin
                    red_next = v_s4_reg; green_next = mid1;     blue_next = m_s4_reg;
                end
                SEXT_RED_DOWN:
                begin
                    red_next = mid2;     green_next = v_s4_reg; blue_next = m_s4_reg;
                end
                SEXT_BLUE_UP:
                begin
                    red_next = m_s4_reg; green_next = v_s4_reg; blue_next = mid1;
                end
                SEXT_GREEN_DOWN:
                begin
                    red_next = m_s4_reg; green_next = mid2;     blue_next = v_s4_reg;
                end
                SEXT_RED_UP:
                begin
                    red_next = mid1;     green_next = m_s4_reg; blue_next = v_s4_reg;
                end
                default:
                begin
                    red_next = v_s4_reg; green_next = m_s4_reg; blue_next = mid2;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[5])
        begin
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
        end
    end

    // Output packing
    assign m_axis_tvalid = vld_reg[NSTAGE];
    assign m_axis_tdata  = OUT_TDATA_W'({blue_reg, green_reg, red_reg});

    // Assertions
    `ASSERT_IMPL(a_ready_when_out_empty, !vld_reg[NSTAGE], s_axis_tready)
    `ASSERT_IMPL(a_full_stall_blocks, (&vld_reg) && !m_axis_tready, !s_axis_tready)
    `ASSERT_IMPL(a_top_above_bottom, vld_reg[3], v_s3_reg >= m_s3_reg)
    `ASSERT_IMPL(a_ramp_within_span, vld_reg[4] && (v_s4_reg >= m_s4_reg),
                 ramp_s4_reg <= (v_s4_reg - m_s4_reg))

endmodule
